FILE: sv/pkp_pkg.sv
// Shared types, codes and command/status structs of the polynomial kernel perceptron.
package pkp_pkg;

    // Operation codes of the input item.
    localparam logic [1:0] OP_SCORE   = 2'd0;
    localparam logic [1:0] OP_UPDATE  = 2'd1;
    localparam logic [1:0] OP_AVERAGE = 2'd2;

    // Result status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_BOUND = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_DEGREE  = 2'd0;
    localparam logic [1:0] CFG_BIAS    = 2'd1;
    localparam logic [1:0] CFG_AVG_CNT = 2'd2;
    localparam logic [1:0] CFG_DIM     = 2'd3;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic signed [31:0] ONE_Q16 = 32'sh0001_0000;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [15:0] element;
        logic [8:0]         vector_index;
        logic signed [31:0] weight_change;
        logic               use_average;
    } t_in;

    typedef struct packed {
        logic signed [31:0] score;
        logic [1:0]         status;
    } t_out;

    typedef struct packed {
        logic       ib_we;
        logic       vs_we;
        logic       capture;
        logic       dot_rd;
        logic       dot_clear;
        logic       total_clear;
        logic       base_load;
        logic       pow_mul;
        logic       pow_rnd;
        logic       w_mul;
        logic       w_rnd;
        logic       upd_wr;
        logic       app_wr;
        logic       div_start;
        logic       avg_wr;
        logic       out_load;
        logic       out_score;
        logic [1:0] out_status;
    } t_cmd;

    typedef struct packed {
        logic dot_busy;
        logic div_busy;
        logic div_done;
        logic out_free;
    } t_sts;

endpackage

FILE: sv/pkp_div.sv
// Iterative signed-by-unsigned divider, one quotient bit per cycle, truncating toward zero.
module pkp_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [55:0] i_dividend,
    input  logic [23:0]        i_divisor,
    output logic signed [55:0] o_quotient,
    output logic               o_busy,
    output logic               o_done
);
    localparam int QW = 56;
    localparam int RW = 24;

    logic [RW-1:0] r_rem;
    logic [QW-1:0] r_quo;
    logic [5:0]    r_cnt;
    logic          r_neg;
    logic          r_busy;
    logic          r_done;
    logic [RW:0]   trial;
    logic [RW:0]   diff;

    assign trial = {r_rem, r_quo[QW-1]};
    assign diff  = trial - {1'b0, i_divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == 6'(QW - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_neg <= i_dividend[QW-1];
            r_quo <= i_dividend[QW-1] ? QW'(-i_dividend) : QW'(i_dividend);
        end else if (r_busy) begin
            if (trial >= {1'b0, i_divisor}) begin
                r_rem <= diff[RW-1:0];
                r_quo <= {r_quo[QW-2:0], 1'b1};
            end else begin
                r_rem <= trial[RW-1:0];
                r_quo <= {r_quo[QW-2:0], 1'b0};
            end
        end
    end

    assign o_quotient = r_neg ? -$signed(r_quo) : $signed(r_quo);
    assign o_busy     = r_busy;
    assign o_done     = r_done;

endmodule

FILE: sv/pkp_dp.sv
// Datapath: configuration registers, vector and weight memories, multiply and saturate stages.
module pkp_dp #(
    parameter int MAX_VECTORS = 256,
    parameter int MAX_DIM     = 64,
    localparam int AW = (MAX_VECTORS > 1) ? $clog2(MAX_VECTORS) : 1,
    localparam int PW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1,
    localparam int DW = $clog2(MAX_DIM + 1)
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  pkp_pkg::t_cmd                       i_cmd,
    output pkp_pkg::t_sts                       o_sts,
    input  pkp_pkg::t_in                        i_in,
    input  logic [AW-1:0]                       i_vs_row,
    input  logic [PW-1:0]                       i_col,
    input  logic [AW-1:0]                       i_w_addr,
    input  logic                                i_cfg_we,
    input  logic [pkp_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [pkp_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    output logic [3:0]                          o_degree,
    output logic [DW-1:0]                       o_dim,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output pkp_pkg::t_out                       o_out
);
    localparam int DTW = 34 + PW;
    localparam int TW  = 33 + AW;
    localparam int VS_DEPTH = MAX_VECTORS * (2 ** PW);
    localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
    localparam logic signed [63:0] S32_MIN = -64'sd2147483648;
    localparam logic signed [55:0] S56_MAX = {1'b0, {55{1'b1}}};
    localparam logic signed [55:0] S56_MIN = {1'b1, {55{1'b0}}};

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > S32_MAX) r = 32'sh7FFF_FFFF;
        else if (v < S32_MIN) r = 32'sh8000_0000;
        else r = v[31:0];
        return r;
    endfunction

    function automatic logic signed [31:0] rnd16(input logic signed [63:0] p);
        return sat32((p + 64'sd32768) >>> 16);
    endfunction

    // Configuration registers.
    logic [3:0]         r_degree;
    logic signed [15:0] r_bias;
    logic [23:0]        r_avg_cnt;
    logic [6:0]         r_dimension;
    logic [DW-1:0]      eff_dim;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_degree    <= 4'd2;
            r_bias      <= '0;
            r_avg_cnt   <= 24'd1;
            r_dimension <= 7'd64;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                pkp_pkg::CFG_DEGREE:  r_degree    <= i_cfg_data[3:0];
                pkp_pkg::CFG_BIAS:    r_bias      <= i_cfg_data[15:0];
                pkp_pkg::CFG_AVG_CNT: r_avg_cnt   <= i_cfg_data[23:0];
                pkp_pkg::CFG_DIM:     r_dimension <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // Effective dimension clamps to 1..MAX_DIM.
    always_comb begin
        if (r_dimension == '0) eff_dim = DW'(1);
        else if (int'(r_dimension) > MAX_DIM) eff_dim = DW'(MAX_DIM);
        else eff_dim = DW'(r_dimension);
    end

    assign o_degree = r_degree;
    assign o_dim    = eff_dim;

    // Captured operands of the item that started the current operation.
    logic signed [31:0] r_change;
    logic               r_use_avg;
    logic signed [55:0] r_scaled;
    logic signed [56:0] scaled_full;

    assign scaled_full = r_change * $signed({1'b0, r_avg_cnt});

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_change  <= i_in.weight_change;
            r_use_avg <= i_in.use_average;
        end
        r_scaled <= scaled_full[55:0];
    end

    // Vector store and instance buffer.
    logic signed [15:0] vs_mem [VS_DEPTH];
    logic signed [15:0] ib_mem [MAX_DIM];
    logic signed [15:0] r_vs_q;
    logic signed [15:0] r_ib_q;

    always_ff @(posedge i_clk) begin
        if (i_cmd.vs_we) vs_mem[{i_vs_row, i_col}] <= i_in.element;
        r_vs_q <= vs_mem[{i_vs_row, i_col}];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ib_we) ib_mem[i_col] <= i_in.element;
        r_ib_q <= ib_mem[i_col];
    end

    // Weight memories.
    logic signed [31:0] alpha_mem [MAX_VECTORS];
    logic signed [55:0] beta_mem  [MAX_VECTORS];
    logic signed [31:0] avg_mem   [MAX_VECTORS];
    logic signed [31:0] r_alpha_q;
    logic signed [55:0] r_beta_q;
    logic signed [31:0] r_avg_q;
    logic signed [56:0] beta_sum;
    logic signed [55:0] beta_new;
    logic signed [55:0] quotient;
    logic               div_busy;
    logic               div_done;

    assign beta_sum = 57'(r_beta_q) + 57'(r_scaled);

    always_comb begin
        if (beta_sum[56] != beta_sum[55]) beta_new = beta_sum[56] ? S56_MIN : S56_MAX;
        else beta_new = beta_sum[55:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.upd_wr) begin
            alpha_mem[i_w_addr] <= sat32(64'(r_alpha_q) + 64'(r_change));
            beta_mem[i_w_addr]  <= beta_new;
        end else if (i_cmd.app_wr) begin
            alpha_mem[i_w_addr] <= r_change;
            beta_mem[i_w_addr]  <= r_scaled;
        end
        r_alpha_q <= alpha_mem[i_w_addr];
        r_beta_q  <= beta_mem[i_w_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.avg_wr) avg_mem[i_w_addr] <= sat32(64'(r_alpha_q) - 64'(quotient));
        r_avg_q <= avg_mem[i_w_addr];
    end

    pkp_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_beta_q),
        .i_divisor  ((r_avg_cnt == '0) ? 24'd1 : r_avg_cnt),
        .o_quotient (quotient),
        .o_busy     (div_busy),
        .o_done     (div_done)
    );

    // Dot product pipeline: read, multiply, accumulate.
    logic               r_v1;
    logic               r_v2;
    logic signed [31:0] r_dprod;
    logic signed [DTW-1:0] r_dot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.dot_rd;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dprod <= r_vs_q * r_ib_q;
        if (i_cmd.dot_clear) r_dot <= DTW'(r_bias) <<< 12;
        else if (r_v2) r_dot <= r_dot + DTW'(r_dprod);
    end

    // Power and weight product share one multiplier; the score sum accumulates the rounded weight products.
    logic signed [31:0] r_base;
    logic signed [31:0] r_pacc;
    logic signed [63:0] r_prod;
    logic signed [TW-1:0] r_total;
    logic signed [31:0] w_sel;
    logic signed [31:0] mul_a;
    logic signed [31:0] mul_b;

    assign w_sel = r_use_avg ? r_avg_q : r_alpha_q;
    assign mul_a = i_cmd.pow_mul ? r_pacc : w_sel;
    assign mul_b = i_cmd.pow_mul ? r_base : r_pacc;

    always_ff @(posedge i_clk) begin
        if (i_cmd.base_load) begin
            r_base <= sat32((64'(r_dot) + 64'sd128) >>> 8);
            r_pacc <= pkp_pkg::ONE_Q16;
        end else if (i_cmd.pow_rnd) begin
            r_pacc <= rnd16(r_prod);
        end
        if (i_cmd.pow_mul || i_cmd.w_mul) r_prod <= mul_a * mul_b;
        if (i_cmd.total_clear) r_total <= '0;
        else if (i_cmd.w_rnd) r_total <= r_total + TW'(rnd16(r_prod));
    end

    // Output register.
    logic          r_out_valid;
    pkp_pkg::t_out r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_out_valid <= 1'b0;
        else if (i_cmd.out_load) r_out_valid <= 1'b1;
        else if (i_out_ready) r_out_valid <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.score  <= i_cmd.out_score ? sat32(64'(r_total)) : '0;
            r_out.status <= i_cmd.out_status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign o_sts.dot_busy = r_v1 || r_v2;
    assign o_sts.div_busy = div_busy;
    assign o_sts.div_done = div_done;
    assign o_sts.out_free = !r_out_valid || i_out_ready;

endmodule

FILE: sv/pkp_ctrl.sv
// Controller: sequences element loading, scoring, weight updates and averaging.
module pkp_ctrl #(
    parameter int MAX_VECTORS = 256,
    parameter int MAX_DIM     = 64,
    localparam int AW = (MAX_VECTORS > 1) ? $clog2(MAX_VECTORS) : 1,
    localparam int PW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1,
    localparam int DW = $clog2(MAX_DIM + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  pkp_pkg::t_in  i_in,
    input  pkp_pkg::t_sts i_sts,
    input  logic [3:0]    i_degree,
    input  logic [DW-1:0] i_dim,
    output pkp_pkg::t_cmd o_cmd,
    output logic [AW-1:0] o_vs_row,
    output logic [PW-1:0] o_col,
    output logic [AW-1:0] o_w_addr
);
    localparam int CW = $clog2(MAX_VECTORS + 1);

    typedef enum logic [12:0] {
        S_IDLE     = 13'b0000000000001,
        S_DOT      = 13'b0000000000010,
        S_DOT_END  = 13'b0000000000100,
        S_POW_MUL  = 13'b0000000001000,
        S_POW_RND  = 13'b0000000010000,
        S_W_MUL    = 13'b0000000100000,
        S_W_RND    = 13'b0000001000000,
        S_UPD_RD   = 13'b0000010000000,
        S_UPD_WR   = 13'b0000100000000,
        S_AVG_RD   = 13'b0001000000000,
        S_AVG_ST   = 13'b0010000000000,
        S_AVG_WAIT = 13'b0100000000000,
        S_OUT      = 13'b1000000000000
    } t_state;

    t_state        r_state, n_state;
    logic [PW-1:0] r_pos, n_pos;
    logic [CW-1:0] r_count, n_count;
    logic [AW-1:0] r_j, n_j;
    logic [PW-1:0] r_i, n_i;
    logic [3:0]    r_pc, n_pc;
    logic [AW-1:0] r_idx, n_idx;
    logic          r_app, n_app;
    logic [1:0]    r_ostat, n_ostat;
    logic          r_osel, n_osel;
    logic          last;
    pkp_pkg::t_cmd cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pos   <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_j     <= n_j;
        r_i     <= n_i;
        r_pc    <= n_pc;
        r_idx   <= n_idx;
        r_app   <= n_app;
        r_ostat <= n_ostat;
        r_osel  <= n_osel;
    end

    assign last = (int'(r_pos) + 1) >= int'(i_dim);

    always_comb begin
        n_state = r_state;
        n_pos   = r_pos;
        n_count = r_count;
        n_j     = r_j;
        n_i     = r_i;
        n_pc    = r_pc;
        n_idx   = r_idx;
        n_app   = r_app;
        n_ostat = r_ostat;
        n_osel  = r_osel;
        cmd     = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    case (i_in.op)
                        pkp_pkg::OP_SCORE: begin
                            cmd.ib_we = 1'b1;
                            n_pos = last ? '0 : r_pos + 1'b1;
                            if (last) begin
                                cmd.capture     = 1'b1;
                                cmd.total_clear = 1'b1;
                                n_j     = '0;
                                n_i     = '0;
                                n_ostat = pkp_pkg::ST_OK;
                                n_osel  = 1'b1;
                                n_state = (r_count == '0) ? S_OUT : S_DOT;
                            end
                        end
                        pkp_pkg::OP_UPDATE: begin
                            cmd.vs_we = int'(r_count) < MAX_VECTORS;
                            n_pos = last ? '0 : r_pos + 1'b1;
                            if (last) begin
                                cmd.capture = 1'b1;
                                n_idx   = AW'(i_in.vector_index);
                                n_osel  = 1'b0;
                                n_ostat = pkp_pkg::ST_OK;
                                if (int'(i_in.vector_index) < int'(r_count)) begin
                                    n_app   = 1'b0;
                                    n_state = S_UPD_RD;
                                end else if (int'(i_in.vector_index) == int'(r_count)) begin
                                    if (int'(r_count) < MAX_VECTORS) begin
                                        n_app   = 1'b1;
                                        n_state = S_UPD_RD;
                                    end else begin
                                        n_ostat = pkp_pkg::ST_FULL;
                                        n_state = S_OUT;
                                    end
                                end else begin
                                    n_ostat = pkp_pkg::ST_BOUND;
                                    n_state = S_OUT;
                                end
                            end
                        end
                        pkp_pkg::OP_AVERAGE: begin
                            if (r_count != '0) begin
                                n_j     = '0;
                                n_state = S_AVG_RD;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_DOT: begin
                cmd.dot_rd    = 1'b1;
                cmd.dot_clear = (r_i == '0);
                if ((int'(r_i) + 1) >= int'(i_dim)) begin
                    n_i     = '0;
                    n_state = S_DOT_END;
                end else begin
                    n_i = r_i + 1'b1;
                end
            end
            S_DOT_END: begin
                if (!i_sts.dot_busy) begin
                    cmd.base_load = 1'b1;
                    n_pc    = '0;
                    n_state = (i_degree == '0) ? S_W_MUL : S_POW_MUL;
                end
            end
            S_POW_MUL: begin
                cmd.pow_mul = 1'b1;
                n_state     = S_POW_RND;
            end
            S_POW_RND: begin
                cmd.pow_rnd = 1'b1;
                if ((int'(r_pc) + 1) >= int'(i_degree)) begin
                    n_state = S_W_MUL;
                end else begin
                    n_pc    = r_pc + 1'b1;
                    n_state = S_POW_MUL;
                end
            end
            S_W_MUL: begin
                cmd.w_mul = 1'b1;
                n_state   = S_W_RND;
            end
            S_W_RND: begin
                cmd.w_rnd = 1'b1;
                if ((int'(r_j) + 1) >= int'(r_count)) begin
                    n_state = S_OUT;
                end else begin
                    n_j     = r_j + 1'b1;
                    n_state = S_DOT;
                end
            end
            S_UPD_RD: begin
                n_state = S_UPD_WR;
            end
            S_UPD_WR: begin
                if (r_app) begin
                    cmd.app_wr = 1'b1;
                    n_count    = r_count + 1'b1;
                end else begin
                    cmd.upd_wr = 1'b1;
                end
                n_state = S_OUT;
            end
            S_AVG_RD: begin
                n_state = S_AVG_ST;
            end
            S_AVG_ST: begin
                cmd.div_start = 1'b1;
                n_state       = S_AVG_WAIT;
            end
            S_AVG_WAIT: begin
                if (i_sts.div_done) begin
                    cmd.avg_wr = 1'b1;
                    if ((int'(r_j) + 1) >= int'(r_count)) begin
                        n_state = S_IDLE;
                    end else begin
                        n_j     = r_j + 1'b1;
                        n_state = S_AVG_RD;
                    end
                end
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    cmd.out_load   = 1'b1;
                    cmd.out_score  = r_osel;
                    cmd.out_status = r_ostat;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_cmd      = cmd;
    assign o_in_ready = (r_state == S_IDLE);
    assign o_vs_row   = (r_state == S_IDLE) ? r_count[AW-1:0] : r_j;
    assign o_col      = (r_state == S_IDLE) ? r_pos : r_i;
    assign o_w_addr   = (r_state == S_UPD_RD || r_state == S_UPD_WR) ? r_idx : r_j;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_count) <= MAX_VECTORS)
        else $error("vector count exceeds the store size");

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_pos) < MAX_DIM)
        else $error("element position beyond the buffer");

    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> i_sts.out_free)
        else $error("result loaded over an untaken result");

    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.div_start |-> !i_sts.div_busy)
        else $error("divider restarted while busy");
`endif

endmodule

FILE: sv/polynomial_kernel_perceptron.sv
// Top level of the averaged kernel perceptron with a polynomial kernel.
//
// Usage: items arrive on the input channel (i_in_valid / o_in_ready / i_in_data)
// and results leave on the output channel (o_out_valid / i_out_ready / o_out_data).
// Op 0 and op 1 elements are taken one per cycle while the block is idle. The last
// element of an op 0 instance starts a score: the stored vectors are scored one after
// another, each through a dot product over the single read port of the vector store
// and the power and weight products on the one shared 32x32 multiplier. An empty
// store answers score 0. The last element of an op 1 vector updates or appends the
// weights, or is refused when the index is out of range or the store is full, and
// returns a result with score 0 and a status. Op 2 walks all stored vectors with a
// bit-serial divider and returns no result. Input is not accepted while a score,
// update or average is in progress.
// Results sit in an output register; while the receiver stalls, element loading
// continues, and a finished result waits in the controller until the register frees.
// Reset (synchronous, active low) empties the store, clears the element position and
// restores the configuration defaults; memories are not cleared. Configuration writes
// belong only to idle periods: the user must keep to this; the block does not enforce it.
module polynomial_kernel_perceptron #(
    parameter int MAX_VECTORS = 256,
    parameter int MAX_DIM     = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  pkp_pkg::t_in                   i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output pkp_pkg::t_out                  o_out_data,
    input  logic                           i_cfg_we,
    input  logic [pkp_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [pkp_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    localparam int AW = (MAX_VECTORS > 1) ? $clog2(MAX_VECTORS) : 1;
    localparam int PW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int DW = $clog2(MAX_DIM + 1);

    // Commands from the controller, status back from the datapath.
    pkp_pkg::t_cmd cmd;
    pkp_pkg::t_sts sts;
    logic [AW-1:0] vs_row;
    logic [PW-1:0] col;
    logic [AW-1:0] w_addr;
    logic [3:0]    degree;
    logic [DW-1:0] dim;

    pkp_ctrl #(
        .MAX_VECTORS (MAX_VECTORS),
        .MAX_DIM     (MAX_DIM)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in       (i_in_data),
        .i_sts      (sts),
        .i_degree   (degree),
        .i_dim      (dim),
        .o_cmd      (cmd),
        .o_vs_row   (vs_row),
        .o_col      (col),
        .o_w_addr   (w_addr)
    );

    // The datapath owns the configuration registers, all memories and the output register.
    pkp_dp #(
        .MAX_VECTORS (MAX_VECTORS),
        .MAX_DIM     (MAX_DIM)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in        (i_in_data),
        .i_vs_row    (vs_row),
        .i_col       (col),
        .i_w_addr    (w_addr),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_degree    (degree),
        .o_dim       (dim),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out_data)
    );

endmodule
